>>> sv/rine_pkg.sv
// Shared types, constants and helpers of the range image normal estimation block.
// No dependencies; used by range_image_normal_estimation_top.
package rine_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 1024;
    localparam int NORM_FRAC  = 14;

    localparam int SQ_BITS = 31;                      // root bits of the length
    localparam int DV_BITS = NORM_FRAC + 1;           // quotient bits
    localparam int ST_SQ0  = 10;                      // stage of the first root step
    localparam int ST_DV0  = ST_SQ0 + SQ_BITS + 1;    // stage of the dividend setup
    localparam int ST_OUT  = ST_DV0 + DV_BITS + 1;    // output register stage

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // One stored pixel: vertex x, y, z (low to high) and depth valid flag.
    typedef struct packed {
        logic            ok;
        logic [2:0][31:0] p;
    } t_pix;

    // Item bookkeeping that travels with every stage.
    typedef struct packed {
        logic [9:0]  row;
        logic [10:0] col;
        logic        en;    // normal of the row above is produced
        logic        own;   // last row: own zero result
        logic        fend;  // final pixel of the frame
        logic        ok;    // normal is computable
    } t_meta;

    // Smallest shift that brings the value below 2^lim.
    function automatic logic [5:0] f_red_shift(input logic [41:0] m, input logic [5:0] lim);
        logic [5:0] s;
        s = '0;
        for (int i = 0; i < 42; i++) begin
            if (m[i] && (6'(i) >= lim)) begin
                s = 6'(i) - lim + 6'd1;
            end
        end
        return s;
    endfunction

endpackage

>>> sv/range_image_normal_estimation_top.sv
// Top level of the range image normal estimation block: line buffer and pipeline.
// Depends on rine_pkg.
//
// Pixels stream in row-major order, one word per pixel (x, y, z, depth in
// Q15.16). The previous row is kept in a 2048-entry line buffer with one
// write and two read ports. When pixel (c,r+1) arrives the normal of (c,r)
// comes out as the normalized cross product of (lower - centre) x (right -
// centre), in Q1.14; the first row produces nothing and each pixel of the
// last row also yields a zero word for itself. One pixel is accepted every
// cycle unless the pipeline holds; a last-row pixel with a normal takes two
// output words. Length normalization uses the 31-step pipelined square root
// and the 15-step pipelined divider. The whole pipeline holds when the output
// word is not taken. The user sets width and height over the APB port (byte
// addresses 0 and 4) while the block is idle; the block does not enforce it.
module range_image_normal_estimation_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // pixel input
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // vertex_x, vertex_y, vertex_z, range_depth
    // normal output
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata,   // normal_x, normal_y, normal_z, pixel_row,
                                      // pixel_col, normal_found, zero pad
    output logic         o_m_tlast,   // last_of_run
    output logic         o_m_tuser    // frame_end
);

    localparam int NS = rine_pkg::ST_OUT;

    // ---------------- configuration registers ----------------
    logic [11:0] r_width;
    logic [10:0] r_height;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd1024;
            r_height <= 11'd64;
        end else if (cfg_wr) begin
            unique case (rine_pkg::t_reg_idx'(paddr[2]))
                rine_pkg::REG_WIDTH:  r_width  <= pwdata[11:0];
                rine_pkg::REG_HEIGHT: r_height <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rine_pkg::t_reg_idx'(paddr[2]))
            rine_pkg::REG_WIDTH:  prdata = {20'd0, r_width};
            rine_pkg::REG_HEIGHT: prdata = {21'd0, r_height};
            default:              prdata = '0;
        endcase
    end

    // ---------------- position counters ----------------
    logic [11:0] w_c;
    logic [10:0] h_c;
    logic [10:0] r_col;
    logic [9:0]  r_row;
    logic        restart;
    logic [10:0] cc;
    logic [9:0]  rr;
    logic [11:0] col_p1;
    logic [10:0] row_p1;
    logic        col_wrap;
    logic        row_wrap;
    logic        last_row;
    logic        adv;
    logic        acc;

    assign w_c = (r_width < 12'd2) ? 12'd2 :
                 (r_width > 12'(rine_pkg::MAX_WIDTH)) ? 12'(rine_pkg::MAX_WIDTH) : r_width;
    assign h_c = (r_height < 11'd2) ? 11'd2 :
                 (r_height > 11'(rine_pkg::MAX_HEIGHT)) ? 11'(rine_pkg::MAX_HEIGHT) : r_height;

    assign restart  = ({1'b0, r_col} >= w_c) || ({1'b0, r_row} >= h_c);
    assign cc       = restart ? '0 : r_col;
    assign rr       = restart ? '0 : r_row;
    assign col_p1   = {1'b0, cc} + 12'd1;
    assign row_p1   = {1'b0, rr} + 11'd1;
    assign col_wrap = col_p1 >= w_c;
    assign row_wrap = row_p1 >= h_c;
    assign last_row = ({1'b0, rr} == (h_c - 11'd1));

    assign o_s_tready = adv;
    assign acc        = i_s_tvalid & adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= col_wrap ? '0 : col_p1[10:0];
            r_row <= col_wrap ? (row_wrap ? '0 : row_p1[9:0]) : rr;
        end
    end

    // ---------------- line buffer ----------------
    rine_pkg::t_pix r_mem [rine_pkg::MAX_WIDTH];
    rine_pkg::t_pix cur;
    rine_pkg::t_pix r_rda;    // previous row, same column
    rine_pkg::t_pix r_rdb;    // previous row, next column
    rine_pkg::t_pix r_first;  // previous row, column zero
    rine_pkg::t_pix r_cur1;
    logic           r_usef1;
    logic           r_c01;

    assign cur.p  = i_s_tdata[95:0];
    assign cur.ok = $signed(i_s_tdata[127:96]) > 32'sd0;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mem[cc] <= cur;
            r_rda     <= r_mem[cc];
            r_rdb     <= r_mem[col_p1[10:0]];
            r_cur1    <= cur;
            r_usef1   <= col_wrap;
            r_c01     <= (cc == '0);
        end
    end

    // ---------------- valid bits and item bookkeeping ----------------
    logic            r_vld  [1:NS];
    rine_pkg::t_meta r_meta [1:NS];
    logic            n_vld  [1:NS-1];
    rine_pkg::t_meta n_meta [1:NS-1];
    logic            ok2;
    logic            cross_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[1] <= 1'b0;
        end else if (adv) begin
            r_vld[1] <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_meta[1].row  <= rr;
            r_meta[1].col  <= cc;
            r_meta[1].en   <= (rr != '0);
            r_meta[1].own  <= last_row;
            r_meta[1].fend <= last_row & col_wrap;
            r_meta[1].ok   <= 1'b1;
        end
    end

    always_comb begin
        for (int k = 1; k < NS; k++) begin
            n_vld[k]  = r_vld[k];
            n_meta[k] = r_meta[k];
        end
        // first row items carry no result
        n_vld[1]     = r_vld[1] & (r_meta[1].en | r_meta[1].own);
        n_meta[1].ok = ok2;
        n_meta[6].ok = r_meta[6].ok & cross_nz;
    end

    for (genvar k = 1; k < NS; k++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (adv) begin
                r_vld[k+1] <= n_vld[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_meta[k+1] <= n_meta[k];
            end
        end
    end

    // Column zero of the row above is the right neighbor of the last column.
    always_ff @(posedge i_clk) begin
        if (adv && r_vld[1] && r_c01) begin
            r_first <= r_rda;
        end
    end

    // ---------------- stage 2: differences ----------------
    rine_pkg::t_pix   rgt;
    logic signed [32:0] n_u2 [3];
    logic signed [32:0] n_v2 [3];
    logic signed [32:0] r_u2 [3];
    logic signed [32:0] r_v2 [3];

    assign rgt = r_usef1 ? r_first : r_rdb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u2[i] = 33'($signed(rgt.p[i]))    - 33'($signed(r_rda.p[i]));
            n_v2[i] = 33'($signed(r_cur1.p[i])) - 33'($signed(r_rda.p[i]));
        end
        ok2 = r_rda.ok & rgt.ok & r_cur1.ok &
              ((n_u2[0] != '0) | (n_u2[1] != '0) | (n_u2[2] != '0)) &
              ((n_v2[0] != '0) | (n_v2[1] != '0) | (n_v2[2] != '0));
    end

    // ---------------- stage 3: magnitudes ----------------
    logic [32:0] r_um3 [3];
    logic [32:0] r_vm3 [3];
    logic [2:0]  r_us3;
    logic [2:0]  r_vs3;

    // ---------------- stage 4: reduce to 20 bits ----------------
    logic [5:0]         su;
    logic [5:0]         sv;
    logic [32:0]        tu [3];
    logic [32:0]        tv [3];
    logic signed [20:0] n_ur4 [3];
    logic signed [20:0] n_vr4 [3];
    logic signed [20:0] r_ur4 [3];
    logic signed [20:0] r_vr4 [3];

    always_comb begin
        su = rine_pkg::f_red_shift({9'd0, r_um3[0] | r_um3[1] | r_um3[2]}, 6'd20);
        sv = rine_pkg::f_red_shift({9'd0, r_vm3[0] | r_vm3[1] | r_vm3[2]}, 6'd20);
        for (int i = 0; i < 3; i++) begin
            tu[i]    = r_um3[i] >> su;
            tv[i]    = r_vm3[i] >> sv;
            n_ur4[i] = r_us3[i] ? -$signed({1'b0, tu[i][19:0]}) : $signed({1'b0, tu[i][19:0]});
            n_vr4[i] = r_vs3[i] ? -$signed({1'b0, tv[i][19:0]}) : $signed({1'b0, tv[i][19:0]});
        end
    end

    // ---------------- stages 5..9: cross product and squares ----------------
    logic signed [41:0] r_p5 [6];
    logic signed [42:0] r_c6 [3];
    logic [41:0]        r_cm7 [3];
    logic [2:0]         r_cs7;
    logic [5:0]         sc;
    logic [41:0]        tc [3];
    logic [29:0]        r_cm8 [3];
    logic [2:0]         r_cs8;
    logic [59:0]        r_sq9 [3];
    logic [29:0]        r_cm9 [3];
    logic [2:0]         r_cs9;

    assign cross_nz = (r_c6[0] != '0) | (r_c6[1] != '0) | (r_c6[2] != '0);

    always_comb begin
        sc = rine_pkg::f_red_shift(r_cm7[0] | r_cm7[1] | r_cm7[2], 6'd30);
        for (int i = 0; i < 3; i++) begin
            tc[i] = r_cm7[i] >> sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_u2[i]  <= n_u2[i];
                r_v2[i]  <= n_v2[i];
                r_us3[i] <= r_u2[i][32];
                r_vs3[i] <= r_v2[i][32];
                r_um3[i] <= r_u2[i][32] ? 33'(-r_u2[i]) : 33'(r_u2[i]);
                r_vm3[i] <= r_v2[i][32] ? 33'(-r_v2[i]) : 33'(r_v2[i]);
                r_ur4[i] <= n_ur4[i];
                r_vr4[i] <= n_vr4[i];
                r_cs7[i] <= r_c6[i][42];
                r_cm7[i] <= r_c6[i][42] ? 42'(-r_c6[i]) : 42'(r_c6[i]);
                r_cm8[i] <= tc[i][29:0];
                r_cs8[i] <= r_cs7[i];
                r_sq9[i] <= 60'(r_cm8[i]) * 60'(r_cm8[i]);
                r_cm9[i] <= r_cm8[i];
                r_cs9[i] <= r_cs8[i];
            end
            // c = v x u
            r_p5[0] <= r_vr4[1] * r_ur4[2];
            r_p5[1] <= r_vr4[2] * r_ur4[1];
            r_p5[2] <= r_vr4[2] * r_ur4[0];
            r_p5[3] <= r_vr4[0] * r_ur4[2];
            r_p5[4] <= r_vr4[0] * r_ur4[1];
            r_p5[5] <= r_vr4[1] * r_ur4[0];
            r_c6[0] <= 43'(r_p5[0]) - 43'(r_p5[1]);
            r_c6[1] <= 43'(r_p5[2]) - 43'(r_p5[3]);
            r_c6[2] <= 43'(r_p5[4]) - 43'(r_p5[5]);
        end
    end

    // ---------------- square root, one bit per stage ----------------
    logic [61:0] r_sq_rem  [0:rine_pkg::SQ_BITS];
    logic [30:0] r_sq_root [0:rine_pkg::SQ_BITS];
    logic [29:0] r_sq_mag  [0:rine_pkg::SQ_BITS][3];
    logic [2:0]  r_sq_sgn  [0:rine_pkg::SQ_BITS];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem[0]  <= 62'(r_sq9[0]) + 62'(r_sq9[1]) + 62'(r_sq9[2]);
            r_sq_root[0] <= '0;
            r_sq_sgn[0]  <= r_cs9;
            for (int i = 0; i < 3; i++) begin
                r_sq_mag[0][i] <= r_cm9[i];
            end
        end
    end

    for (genvar j = 0; j < rine_pkg::SQ_BITS; j++) begin : g_sqrt
        localparam int B = rine_pkg::SQ_BITS - 1 - j;
        logic [63:0] trial;
        assign trial = ({33'd0, r_sq_root[j]} << (B + 1)) + (64'd1 << (2 * B));
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if ({2'b00, r_sq_rem[j]} >= trial) begin
                    r_sq_rem[j+1]  <= r_sq_rem[j] - trial[61:0];
                    r_sq_root[j+1] <= r_sq_root[j] | (31'd1 << B);
                end else begin
                    r_sq_rem[j+1]  <= r_sq_rem[j];
                    r_sq_root[j+1] <= r_sq_root[j];
                end
                r_sq_sgn[j+1] <= r_sq_sgn[j];
                for (int i = 0; i < 3; i++) begin
                    r_sq_mag[j+1][i] <= r_sq_mag[j][i];
                end
            end
        end
    end

    // ---------------- rounded division, one bit per stage ----------------
    logic [44:0]                  r_dv_rem [0:rine_pkg::DV_BITS][3];
    logic [rine_pkg::DV_BITS-1:0] r_dv_q   [0:rine_pkg::DV_BITS][3];
    logic [30:0]                  r_dv_len [0:rine_pkg::DV_BITS];
    logic [2:0]                   r_dv_sgn [0:rine_pkg::DV_BITS];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_len[0] <= r_sq_root[rine_pkg::SQ_BITS];
            r_dv_sgn[0] <= r_sq_sgn[rine_pkg::SQ_BITS];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= ({15'd0, r_sq_mag[rine_pkg::SQ_BITS][i]} << rine_pkg::NORM_FRAC)
                                + {14'd0, r_sq_root[rine_pkg::SQ_BITS] >> 1};
                r_dv_q[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < rine_pkg::DV_BITS; j++) begin : g_div
        localparam int B = rine_pkg::DV_BITS - 1 - j;
        logic [45:0] dsh;
        assign dsh = {15'd0, r_dv_len[j]} << B;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_len[j+1] <= r_dv_len[j];
                r_dv_sgn[j+1] <= r_dv_sgn[j];
                for (int i = 0; i < 3; i++) begin
                    if ({1'b0, r_dv_rem[j][i]} >= dsh) begin
                        r_dv_rem[j+1][i] <= r_dv_rem[j][i] - dsh[44:0];
                        r_dv_q[j+1][i]   <= r_dv_q[j][i] | (rine_pkg::DV_BITS'(1) << B);
                    end else begin
                        r_dv_rem[j+1][i] <= r_dv_rem[j][i];
                        r_dv_q[j+1][i]   <= r_dv_q[j][i];
                    end
                end
            end
        end
    end

    // ---------------- output register ----------------
    logic [15:0] n_nrm [3];
    logic [15:0] r_nrm [3];
    logic [15:0] qx;
    logic        r_phase;   // normal word already sent, own word pending
    logic        is_norm;
    logic        is_last;
    logic        done;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qx = 16'(r_dv_q[rine_pkg::DV_BITS][i]);
            if (qx > 16'(1 << rine_pkg::NORM_FRAC)) begin
                qx = 16'(1 << rine_pkg::NORM_FRAC);
            end
            n_nrm[i] = !r_meta[NS-1].ok ? '0 : (r_dv_sgn[rine_pkg::DV_BITS][i] ? -qx : qx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_nrm[i] <= n_nrm[i];
            end
        end
    end

    assign is_norm = r_meta[NS].en & ~r_phase;
    assign is_last = ~(is_norm & r_meta[NS].own);
    assign done    = r_vld[NS] & i_m_tready & is_last;
    assign adv     = ~r_vld[NS] | done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (adv) begin
            r_phase <= 1'b0;
        end else if (r_vld[NS] && i_m_tready) begin
            r_phase <= 1'b1;
        end
    end

    assign o_m_tvalid = r_vld[NS];
    assign o_m_tlast  = is_last;
    assign o_m_tuser  = is_last & r_meta[NS].fend;
    assign o_m_tdata  = {2'b00,
                         is_norm & r_meta[NS].ok,
                         r_meta[NS].col,
                         is_norm ? (r_meta[NS].row - 10'd1) : r_meta[NS].row,
                         is_norm ? r_nrm[2] : 16'd0,
                         is_norm ? r_nrm[1] : 16'd0,
                         is_norm ? r_nrm[0] : 16'd0};

endmodule

>>> sv/rine_chk.sv
// Port-level checker for range_image_normal_estimation_top, with its bind.
// No package dependencies.
module rine_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    // frame end only on the closing word of a pixel
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("frame end without tlast");

    // a word without a normal carries a zero vector
    a_zero_nrm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[69] |-> o_m_tdata[47:0] == 48'd0)
        else $error("nonzero normal with found clear");

    // the own word of a last-row pixel follows its normal word at once
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid && o_m_tlast)
        else $error("second word of a pixel missing");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed under stall");

endmodule

bind range_image_normal_estimation_top rine_chk u_rine_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
